[rtl/core/mscc_pkg.sv]
// Shared definitions for the MIPS subset core: command, status, opcode and
// funct codes, the execute-result bundle and the address check.
// No dependencies.
package mscc_pkg;

	localparam int MEM_WORDS_DEF = 16384;
	localparam logic [31:0] START_RESET = 32'h0000_0000;

	// Commands carried on the input tuser.
	localparam logic [2:0] CMD_WMEM    = 3'd0;
	localparam logic [2:0] CMD_STEP    = 3'd1;
	localparam logic [2:0] CMD_RREG    = 3'd2;
	localparam logic [2:0] CMD_RMEM    = 3'd3;
	localparam logic [2:0] CMD_RESTART = 3'd4;
	localparam logic [2:0] CMD_WREG    = 3'd5;

	// Result status codes.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FETCH  = 3'd1;
	localparam logic [2:0] ST_OPCODE = 3'd2;
	localparam logic [2:0] ST_FUNCT  = 3'd3;
	localparam logic [2:0] ST_DADDR  = 3'd4;
	localparam logic [2:0] ST_HALTED = 3'd5;

	// Primary opcodes.
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;

	// R-type function codes.
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	localparam logic [31:0] J_REGION_MASK = 32'hF000_0000;

	typedef struct packed {
		logic [2:0]  status;
		logic        wr;
		logic [4:0]  dest;
		logic [31:0] res;
		logic [31:0] next_pc;
		logic        is_load;
		logic        is_store;
		logic [31:0] addr;
	} exec_t;

	// A byte address is usable when word aligned and inside the memory.
	function automatic logic addr_ok(input logic [31:0] addr, input logic [31:0] words);
		addr_ok = (addr[1:0] == 2'b00) && ({2'b00, addr[31:2]} < words);
	endfunction

endpackage

[rtl/core/mscc_mem.sv]
// Word memory of the core: one write port, one registered read port, and
// the clearing sweep that zeroes every word after reset.
// Depends on mscc_pkg.
module mscc_mem import mscc_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	localparam int AW = $clog2(MEM_WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0]   words_q [MEM_WORDS];
	logic [31:0]   rdata_q;
	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;

	// The sweep writes one zero word per cycle, from the bottom up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			words_q[clr_idx_q] <= '0;
		end else if (we) begin
			words_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= words_q[raddr];
		end
	end

	assign busy  = clearing_q;
	assign rdata = rdata_q;

endmodule

[rtl/core/mscc_regfile.sv]
// General register file: 32 words, two registered read ports, one write
// port. Valid bits make every entry read as zero until first written.
// Depends on mscc_pkg.
module mscc_regfile import mscc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	input  logic        re,
	input  logic [4:0]  raddr_a,
	input  logic [4:0]  raddr_b,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);

	logic [31:0] regs_q [32];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic [31:0] vld_q;
	logic        va_q;
	logic        vb_q;
	logic        wr_ok;

	// Register zero is never written, so its valid bit keeps it at zero.
	assign wr_ok = we && (waddr != 5'd0);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			regs_q[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= regs_q[raddr_a];
			rd_b_q <= regs_q[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (wr_ok) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				va_q <= vld_q[raddr_a];
				vb_q <= vld_q[raddr_b];
			end
		end
	end

	assign rdata_a = va_q ? rd_a_q : '0;
	assign rdata_b = vb_q ? rd_b_q : '0;

endmodule

[rtl/core/mscc_exec.sv]
// Instruction decode and execute: computes the result, destination, next
// program counter, data address and fault status of one instruction.
// Depends on mscc_pkg.
module mscc_exec import mscc_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic [31:0] ins,
	input  logic [31:0] pc,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output exec_t       ex
);

	logic [5:0]  op;
	logic [5:0]  fn;
	logic [15:0] imm;
	logic [31:0] ext;
	logic [31:0] sum_ai;
	logic [31:0] pc4;

	assign op     = ins[31:26];
	assign fn     = ins[5:0];
	assign imm    = ins[15:0];
	assign ext    = {{16{imm[15]}}, imm};
	assign sum_ai = a + ext;
	assign pc4    = pc + 32'd4;

	always_comb begin
		ex          = '0;
		ex.status   = ST_OK;
		ex.next_pc  = pc4;
		ex.addr     = sum_ai;
		case (op)
			OP_RTYPE: begin
				ex.wr   = 1'b1;
				ex.dest = ins[15:11];
				case (fn)
					FN_ADD:  ex.res = a + b;
					FN_SUB:  ex.res = a - b;
					FN_AND:  ex.res = a & b;
					FN_OR:   ex.res = a | b;
					FN_SLT:  ex.res = {31'd0, $signed(a) < $signed(b)};
					FN_SLTU: ex.res = {31'd0, a < b};
					default: ex.status = ST_FUNCT;
				endcase
			end
			OP_ADDI: begin
				ex.wr   = 1'b1;
				ex.dest = ins[20:16];
				ex.res  = sum_ai;
			end
			OP_SLTI: begin
				ex.wr   = 1'b1;
				ex.dest = ins[20:16];
				ex.res  = {31'd0, $signed(a) < $signed(ext)};
			end
			OP_SLTIU: begin
				ex.wr   = 1'b1;
				ex.dest = ins[20:16];
				ex.res  = {31'd0, a < ext};
			end
			OP_LUI: begin
				ex.wr   = 1'b1;
				ex.dest = ins[20:16];
				ex.res  = {imm, 16'd0};
			end
			OP_LW: begin
				ex.wr      = 1'b1;
				ex.dest    = ins[20:16];
				ex.is_load = 1'b1;
				if (!addr_ok(sum_ai, 32'(MEM_WORDS))) begin
					ex.status = ST_DADDR;
				end
			end
			OP_SW: begin
				ex.is_store = 1'b1;
				if (!addr_ok(sum_ai, 32'(MEM_WORDS))) begin
					ex.status = ST_DADDR;
				end
			end
			OP_BEQ: begin
				if (a == b) begin
					ex.next_pc = pc4 + {ext[29:0], 2'b00};
				end
			end
			OP_J: begin
				ex.next_pc = (pc4 & J_REGION_MASK) | {4'd0, ins[25:0], 2'b00};
			end
			default: ex.status = ST_OPCODE;
		endcase
		// An all-zero word counts as a fetch fault before any decoding.
		if (ins == 32'd0) begin
			ex.status = ST_FETCH;
		end
	end

endmodule

[rtl/core/mips_single_cycle_core.sv]
// Top level of the MIPS subset core: command sequencer, program counter,
// halt flag and output register around mscc_mem, mscc_regfile, mscc_exec.
// Depends on mscc_pkg and those three modules.
//
// Usage: each request on the s_axis channel carries one command in tuser
// (write memory, step, read register, read memory, restart, write register)
// and its operands in tdata. Every request yields exactly one response on
// m_axis: program counter, halt flag, status and the word read. The start
// address is written over the always-ready cfg channel; the user must do so
// only while no request is in flight, which the block does not enforce.
// The sequencer goes from idle to issue when a request is accepted. Memory
// write, register write, restart, unused commands and a step that is
// refused or has an unusable program counter finish in the issue state;
// register and memory reads finish in a read state; any other step passes
// through fetch and execute, and a step that executes lw also through load,
// as set by the single read port of the word memory (instruction fetch, then
// load data) and the registered register file read. Requests are taken one
// at a time, a new one in the cycle after the previous response is loaded.
// After reset the word memory is swept to zero, one word per cycle, over all
// MEM_WORDS words; s_axis_tready stays low during the sweep. Registers
// read as zero, the program counter is zero and the core is not halted.
// When the receiver stalls, the finished response waits in the output
// register; the next request may already be accepted and is held in its
// final cycle until the output register is free.
module mips_single_cycle_core import mscc_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [13:0] word_index, [18:14] reg_index, [50:19] write_value, [55:51] zero
	input  logic [55:0] s_axis_tdata,
	// [2:0] cmd
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] pc_now, [32] is_halted, [35:33] status, [67:36] read_value,
	// [71:68] zero
	output logic [71:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(MEM_WORDS);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_MEMRD = 3'd2;
	localparam logic [2:0] S_REGRD = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_EXEC  = 3'd5;
	localparam logic [2:0] S_LOAD  = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  state_nx;
	logic [15:0] start_q;
	logic [31:0] pc_q;
	logic        halted_q;

	// Request held for the whole command.
	logic [2:0]  cmd_q;
	logic [13:0] widx_q;
	logic [4:0]  ridx_q;
	logic [31:0] val_q;
	logic [31:0] ins_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] out_pc_q;
	logic        out_halt_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_rv_q;

	logic in_fire;
	logic out_free;
	logic widx_ok;
	logic pc_ok;

	// Response of the current cycle, valid when fin is set.
	logic        fin;
	logic        commit;
	logic [31:0] pc_nx;
	logic        halt_nx;
	logic [2:0]  status_nx;
	logic [31:0] rv_nx;

	// Memory and register file ports.
	logic          mem_busy;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;
	logic          rf_we;
	logic [4:0]    rf_waddr;
	logic [31:0]   rf_wdata;
	logic          rf_re;
	logic [4:0]    rf_raddr_a;
	logic [4:0]    rf_raddr_b;
	logic [31:0]   rf_a;
	logic [31:0]   rf_b;
	exec_t         ex;

	mscc_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (mem_busy),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	mscc_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.re      (rf_re),
		.raddr_a (rf_raddr_a),
		.raddr_b (rf_raddr_b),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// The instruction and both register operands are held stable from the
	// execute cycle through the load cycle, so ex stays valid across both.
	mscc_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
		.ins (ins_q),
		.pc  (pc_q),
		.a   (rf_a),
		.b   (rf_b),
		.ex  (ex)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE) && !mem_busy;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign commit        = fin && out_free;

	assign widx_ok = 32'(widx_q) < 32'(MEM_WORDS);
	assign pc_ok   = addr_ok(pc_q, 32'(MEM_WORDS));

	// Sequencer: decides the response, the side effects and the memory
	// accesses of each cycle. Writes happen only in the committing cycle, so
	// a stall on the output just repeats the same cycle. Every write below
	// sits in a branch that finishes the request, so the output register
	// being free is what lets it commit.
	always_comb begin
		state_nx   = state_q;
		fin        = 1'b0;
		pc_nx      = pc_q;
		halt_nx    = halted_q;
		status_nx  = ST_OK;
		rv_nx      = '0;
		mem_we     = 1'b0;
		mem_waddr  = AW'(widx_q);
		mem_wdata  = val_q;
		mem_re     = 1'b0;
		mem_raddr  = AW'(widx_q);
		rf_we      = 1'b0;
		rf_waddr   = ridx_q;
		rf_wdata   = val_q;
		rf_re      = 1'b0;
		rf_raddr_a = ridx_q;
		rf_raddr_b = ridx_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_nx = S_ISSUE;
				end
			end
			S_ISSUE: begin
				case (cmd_q)
					CMD_WMEM: begin
						fin    = 1'b1;
						mem_we = out_free && widx_ok;
					end
					CMD_RMEM: begin
						mem_re   = 1'b1;
						state_nx = S_MEMRD;
					end
					CMD_RREG: begin
						rf_re    = 1'b1;
						state_nx = S_REGRD;
					end
					CMD_WREG: begin
						fin   = 1'b1;
						rf_we = out_free;
					end
					CMD_RESTART: begin
						fin     = 1'b1;
						pc_nx   = {16'd0, start_q};
						halt_nx = 1'b0;
					end
					CMD_STEP: begin
						if (halted_q) begin
							fin       = 1'b1;
							status_nx = ST_HALTED;
						end else if (!pc_ok) begin
							fin       = 1'b1;
							status_nx = ST_FETCH;
							halt_nx   = 1'b1;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = pc_q[AW+1:2];
							state_nx  = S_FETCH;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_MEMRD: begin
				fin   = 1'b1;
				rv_nx = widx_ok ? mem_rdata : '0;
			end
			S_REGRD: begin
				fin   = 1'b1;
				rv_nx = rf_a;
			end
			S_FETCH: begin
				// Operand addresses come straight from the fetched word.
				rf_re      = 1'b1;
				rf_raddr_a = mem_rdata[25:21];
				rf_raddr_b = mem_rdata[20:16];
				state_nx   = S_EXEC;
			end
			S_EXEC: begin
				if (ex.status != ST_OK) begin
					fin       = 1'b1;
					status_nx = ex.status;
					rv_nx     = ins_q;
					halt_nx   = 1'b1;
				end else if (ex.is_load) begin
					mem_re    = 1'b1;
					mem_raddr = ex.addr[AW+1:2];
					state_nx  = S_LOAD;
				end else begin
					fin       = 1'b1;
					rv_nx     = ins_q;
					pc_nx     = ex.next_pc;
					mem_we    = out_free && ex.is_store;
					mem_waddr = ex.addr[AW+1:2];
					mem_wdata = rf_b;
					rf_we     = out_free && ex.wr;
					rf_waddr  = ex.dest;
					rf_wdata  = ex.res;
				end
			end
			S_LOAD: begin
				fin      = 1'b1;
				rv_nx    = ins_q;
				pc_nx    = ex.next_pc;
				rf_we    = out_free;
				rf_waddr = ex.dest;
				rf_wdata = mem_rdata;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
		if (fin && out_free) begin
			state_nx = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= START_RESET[15:0];
			pc_q        <= START_RESET;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				start_q <= cfg_data;
			end
			if (commit) begin
				pc_q     <= pc_nx;
				halted_q <= halt_nx;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and response payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= s_axis_tuser;
			widx_q <= s_axis_tdata[13:0];
			ridx_q <= s_axis_tdata[18:14];
			val_q  <= s_axis_tdata[50:19];
		end
		if (state_q == S_FETCH) begin
			ins_q <= mem_rdata;
		end
		if (commit) begin
			out_pc_q     <= pc_nx;
			out_halt_q   <= halt_nx;
			out_status_q <= status_nx;
			out_rv_q     <= rv_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_rv_q, out_status_q, out_halt_q, out_pc_q};

endmodule

[bench/testbench.sv]
// Self-checking bench for mips_single_cycle_core: random instruction programs, register
// and memory traffic are driven over the stream ports and every response is checked.
// Depends on mscc_pkg and the core RTL; a shadow model of the core lives in this file.
module testbench import mscc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORDS = MEM_WORDS_DEF;
	localparam int ITEMS = 1500;

	// Command codes the core treats as no-ops, and codes it must reject.
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [5:0] OP_BAD = 6'h3F;
	localparam logic [5:0] FN_BAD = 6'h3F;

	// Response fields, laid out exactly as on m_axis_tdata[67:0].
	typedef struct packed {
		logic [31:0] read_value;
		logic [2:0]  status;
		logic        is_halted;
		logic [31:0] pc_now;
	} core_reply_t;

	// Shadow copy of the core. Every accepted request updates it and leaves the
	// reply the core owes; replies from the core are matched in order.
	class core_shadow;
		logic [31:0] regs [32];
		logic [31:0] mem [WORDS];
		logic [31:0] pc;
		bit halted;
		logic [15:0] start_addr;
		core_reply_t awaited[$];
		int unsigned errors;
		int unsigned matched;
		int unsigned by_status[8];

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			pc = '0;
			halted = 0;
			start_addr = '0;
			errors = 0;
			matched = 0;
			foreach (by_status[i]) by_status[i] = 0;
		endfunction

		function void set_start(logic [15:0] addr);
			start_addr = addr;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function bit word_usable(logic [31:0] addr);
			return addr[1:0] == 2'b00 && addr[31:2] < WORDS;
		endfunction

		// One instruction at the current PC. A fault returns before any state changes.
		function logic [2:0] run_instruction(output logic [31:0] fetched);
			logic [31:0] ins, a, b, ext, nxt, res, ad;
			logic [4:0] dest;
			bit wr;
			fetched = '0;
			if (!word_usable(pc))
				return ST_FETCH;
			ins = mem[pc >> 2];
			fetched = ins;
			if (ins == '0)
				return ST_FETCH;
			a = regs[ins[25:21]];
			b = regs[ins[20:16]];
			ext = {{16{ins[15]}}, ins[15:0]};
			nxt = pc + 32'd4;
			res = '0;
			dest = ins[20:16];
			wr = 0;
			case (ins[31:26])
				OP_RTYPE: begin
					dest = ins[15:11];
					wr = 1;
					case (ins[5:0])
						FN_ADD:  res = a + b;
						FN_SUB:  res = a - b;
						FN_AND:  res = a & b;
						FN_OR:   res = a | b;
						FN_SLT:  res = {31'b0, $signed(a) < $signed(b)};
						FN_SLTU: res = {31'b0, a < b};
						default: return ST_FUNCT;
					endcase
				end
				OP_ADDI: begin
					res = a + ext;
					wr = 1;
				end
				OP_SLTI: begin
					res = {31'b0, $signed(a) < $signed(ext)};
					wr = 1;
				end
				OP_SLTIU: begin
					res = {31'b0, a < ext};
					wr = 1;
				end
				OP_LUI: begin
					res = {ins[15:0], 16'h0000};
					wr = 1;
				end
				OP_LW: begin
					ad = a + ext;
					if (!word_usable(ad))
						return ST_DADDR;
					res = mem[ad >> 2];
					wr = 1;
				end
				OP_SW: begin
					ad = a + ext;
					if (!word_usable(ad))
						return ST_DADDR;
					mem[ad >> 2] = b;
				end
				OP_BEQ: if (a == b) nxt = pc + 32'd4 + {ext[29:0], 2'b00};
				OP_J:   nxt = (nxt & J_REGION_MASK) | {4'b0, ins[25:0], 2'b00};
				default: return ST_OPCODE;
			endcase
			if (wr && dest != 5'd0)
				regs[dest] = res;
			pc = nxt;
			return ST_OK;
		endfunction

		function void take_request(logic [2:0] cmd, logic [13:0] widx, logic [4:0] ridx,
				logic [31:0] val);
			core_reply_t r;
			logic [31:0] word;
			logic [2:0] st;
			word = '0;
			st = ST_OK;
			case (cmd)
				CMD_WMEM: if (widx < WORDS) mem[widx] = val;
				CMD_STEP: begin
					if (halted) begin
						st = ST_HALTED;
					end else begin
						st = run_instruction(word);
						if (st != ST_OK)
							halted = 1;
					end
				end
				CMD_RREG: word = regs[ridx];
				CMD_RMEM: if (widx < WORDS) word = mem[widx];
				CMD_RESTART: begin
					pc = {16'h0000, start_addr};
					halted = 0;
				end
				CMD_WREG: if (ridx != 5'd0) regs[ridx] = val;
				default: ;
			endcase
			r.pc_now = pc;
			r.is_halted = halted;
			r.status = st;
			r.read_value = word;
			if (cmd == CMD_STEP)
				by_status[st]++;
			awaited.push_back(r);
		endfunction

		function void match_response(logic [71:0] data);
			core_reply_t want, got;
			got = core_reply_t'(data[67:0]);
			if (awaited.size() == 0) begin
				$error("response %h arrived with no request outstanding", data);
				errors++;
				return;
			end
			want = awaited.pop_front();
			matched++;
			if (got.pc_now !== want.pc_now) begin
				$error("pc_now: expected %h, got %h", want.pc_now, got.pc_now);
				errors++;
			end
			if (got.is_halted !== want.is_halted) begin
				$error("is_halted: expected %0d, got %0d", want.is_halted, got.is_halted);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %h, got %h", want.read_value, got.read_value);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	core_shadow shadow = new();
	int unsigned sent = 0;
	int unsigned burst_left = 0;
	int unsigned phases_run = 0;

	mips_single_cycle_core #(.MEM_WORDS(WORDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// The receiver picks a new habit whenever rx_tick is a multiple of 200: always ready,
	// random stalls, a repeating eight-bit mask, or ready only when rx_tick is a multiple of six.
	int unsigned rx_tick = 0;
	int unsigned rx_mode = 0;
	logic [7:0] rx_mask = 8'hFF;
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 200 == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_mask <= 8'($urandom);
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= rx_mask[rx_tick % 8] | (rx_mask == 8'h00);
			default: m_axis_tready <= (rx_tick % 6 == 0);
		endcase
	end

	// Responses are sampled at the edge where they are taken.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			shadow.match_response(m_axis_tdata);
	end

	// One request. The sender runs in bursts of random length; between bursts it
	// drops tvalid for a random gap. Returns at the edge the request is taken.
	task automatic send_request(input logic [2:0] cmd, input logic [13:0] widx,
			input logic [4:0] ridx, input logic [31:0] val);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {5'b0, val, ridx, widx};
		do @(posedge clk); while (!s_axis_tready);
		shadow.take_request(cmd, widx, ridx, val);
		sent++;
	endtask

	// Hold off new requests until every response is back, then let the core settle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (shadow.pending() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_start(input logic [15:0] addr);
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow.set_start(addr);
		phases_run++;
	endtask

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [5:0] fn);
		return {OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
	endfunction

	// Operands lean on the corners of signed and unsigned compares.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit known_op(logic [5:0] op);
		return op == OP_RTYPE || op == OP_J || op == OP_BEQ || op == OP_ADDI
			|| op == OP_SLTI || op == OP_SLTIU || op == OP_LUI || op == OP_LW || op == OP_SW;
	endfunction

	function automatic bit known_fn(logic [5:0] fn);
		return fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR
			|| fn == FN_SLT || fn == FN_SLTU;
	endfunction

	// A random instruction for a program placed at word base_idx. Loads and stores
	// use r1..r4, which hold addresses in the data area, so most of them land;
	// branches and jumps mostly stay inside the program.
	function automatic logic [31:0] make_instruction(int base_idx, int len);
		logic [4:0] rs, rt, rd;
		logic [5:0] op, fn;
		logic [15:0] imm;
		int pick, off;
		rs = 5'($urandom_range(0, 31));
		rt = 5'($urandom_range(0, 31));
		rd = 5'($urandom_range(0, 31));
		imm = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: imm = 16'h0000;
				1: imm = 16'h7FFF;
				2: imm = 16'h8000;
				default: imm = 16'hFFFF;
			endcase
		end
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			case ($urandom_range(0, 5))
				0: fn = FN_ADD;
				1: fn = FN_SUB;
				2: fn = FN_AND;
				3: fn = FN_OR;
				4: fn = FN_SLT;
				default: fn = FN_SLTU;
			endcase
			return enc_r(rs, rt, rd, fn);
		end else if (pick < 46) begin
			case ($urandom_range(0, 3))
				0: op = OP_ADDI;
				1: op = OP_SLTI;
				2: op = OP_SLTIU;
				default: op = OP_LUI;
			endcase
			return enc_i(op, rs, rt, imm);
		end else if (pick < 64) begin
			off = $urandom_range(0, 16);
			if ($urandom_range(0, 9) != 0)
				imm = 16'(off * 4 - 32);
			op = $urandom_range(0, 1) ? OP_LW : OP_SW;
			return enc_i(op, 5'($urandom_range(1, 4)), rt, imm);
		end else if (pick < 76) begin
			off = $urandom_range(0, 6);
			if ($urandom_range(0, 1))
				rt = rs;
			return enc_i(OP_BEQ, rs, rt, 16'(off - 3));
		end else if (pick < 86) begin
			if ($urandom_range(0, 7) == 0)
				return {OP_J, 26'($urandom)};
			return {OP_J, 26'(base_idx + $urandom_range(0, len))};
		end else if (pick < 91) begin
			do op = 6'($urandom); while (known_op(op));
			return {op, 26'($urandom)};
		end else if (pick < 96) begin
			do fn = 6'($urandom); while (known_fn(fn));
			return enc_r(rs, rt, rd, fn);
		end else if (pick < 98) begin
			return 32'h0000_0000;
		end
		return $urandom;
	endfunction

	// Anything at all: reads, writes, spare commands, a stray restart or step.
	task automatic send_noise();
		logic [13:0] widx;
		widx = $urandom_range(0, 1) ? 14'(8192 + $urandom_range(0, 63))
			: 14'($urandom_range(0, WORDS - 1));
		send_request(3'($urandom_range(0, 7)), widx, 5'($urandom_range(0, 31)),
			pick_operand());
	endtask

	// Restart, seed the base registers, load a program at the start address and
	// step through it and a little past its end.
	task automatic run_program(input int len);
		int base_idx, count, steps;
		send_request(CMD_RESTART, 14'($urandom_range(0, WORDS - 1)), 5'($urandom_range(0, 31)),
			$urandom);
		for (int i = 1; i <= 4; i++)
			send_request(CMD_WREG, 14'($urandom_range(0, WORDS - 1)), 5'(i),
				32'h8000 + 32'($urandom_range(0, 63)) * 4);
		repeat ($urandom_range(0, 3))
			send_request(CMD_WREG, 14'($urandom_range(0, WORDS - 1)),
				5'($urandom_range(0, 31)), pick_operand());
		base_idx = shadow.start_addr >> 2;
		count = len;
		if (base_idx + count > WORDS)
			count = WORDS - base_idx;
		for (int i = 0; i < count; i++)
			send_request(CMD_WMEM, 14'(base_idx + i), 5'($urandom_range(0, 31)),
				make_instruction(base_idx, len));
		steps = len + $urandom_range(0, 4);
		for (int i = 0; i < steps; i++) begin
			send_request(CMD_STEP, 14'($urandom_range(0, WORDS - 1)),
				5'($urandom_range(0, 31)), $urandom);
			if ($urandom_range(0, 7) == 0)
				send_noise();
		end
	endtask

	initial begin
		logic [15:0] plan[6];
		plan[0] = 16'(4 * $urandom_range(0, 2047));
		plan[1] = 16'hFFFC;
		plan[2] = 16'h0003;
		plan[3] = 16'(4 * $urandom_range(2048, 16383));
		plan[4] = 16'(4 * $urandom_range(0, 16383));
		plan[5] = 16'h0000;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening, run from start address zero. The first request waits out
		// the memory clear that follows reset.
		send_request(CMD_WREG, 14'h0000, 5'd31, 32'hFFFF_FFFF);
		send_request(CMD_WREG, 14'h3FFF, 5'd0, 32'hA5A5_A5A5);
		send_request(CMD_RREG, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_RREG, 14'h0000, 5'd31, 32'h0000_0000);
		send_request(CMD_WMEM, 14'h3FFF, 5'd0, 32'hFFFF_FFFF);
		send_request(CMD_RMEM, 14'h3FFF, 5'd0, 32'h0000_0000);
		send_request(CMD_RMEM, 14'h0000, 5'd31, 32'h0000_0000);
		// Empty memory: the fetch of a zero word halts, then a step is refused.
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_SPARE6, 14'h2AAA, 5'd21, 32'h5555_5555);
		send_request(CMD_SPARE7, 14'h1555, 5'd10, 32'hAAAA_AAAA);
		send_request(CMD_RESTART, 14'h0000, 5'd0, 32'h0000_0000);
		// Unknown opcode, then unknown funct.
		send_request(CMD_WMEM, 14'h0000, 5'd0, {OP_BAD, 26'h000_0001});
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_RESTART, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_WMEM, 14'h0000, 5'd0, enc_r(5'd31, 5'd31, 5'd1, FN_BAD));
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_RESTART, 14'h0000, 5'd0, 32'h0000_0000);
		// A store above the memory, then a misaligned load.
		send_request(CMD_WMEM, 14'h0000, 5'd0, enc_i(OP_SW, 5'd0, 5'd31, 16'hFFFC));
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_RESTART, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_WMEM, 14'h0000, 5'd0, enc_i(OP_LW, 5'd31, 5'd1, 16'h0000));
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_RESTART, 14'h0000, 5'd0, 32'h0000_0000);
		// A jump far outside the memory; the next fetch faults with no word read.
		send_request(CMD_WMEM, 14'h0000, 5'd0, {OP_J, 26'h3FF_FFFF});
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);
		send_request(CMD_STEP, 14'h0000, 5'd0, 32'h0000_0000);

		// Random phases, each under its own start address. The core is drained
		// before every write. The top word and a misaligned start get only a few
		// programs since nearly every step there faults.
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_start(plan[ph]);
			if (plan[ph] == 16'hFFFC || plan[ph][1:0] != 2'b00) begin
				repeat (4) run_program($urandom_range(2, 6));
			end else begin
				while (sent < ITEMS * (ph + 1) / 6)
					run_program($urandom_range(3, 12));
			end
		end
		wait_idle();

		$display("summary: %0d requests under %0d start addresses, %0d responses matched",
			sent, phases_run, shadow.matched);
		$display("summary: steps ok %0d, fetch %0d, opcode %0d, funct %0d, data %0d, refused %0d",
			shadow.by_status[ST_OK], shadow.by_status[ST_FETCH], shadow.by_status[ST_OPCODE],
			shadow.by_status[ST_FUNCT], shadow.by_status[ST_DADDR],
			shadow.by_status[ST_HALTED]);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, memory clear included.
	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
